// File: rtl/pfas_pkg.sv
// package for the phase-field alloy stencil step unit
// holds widths, register indexes, fixed-point constants and datapath command codes
`default_nettype none
package pfas_pkg;
    localparam int DataWidth = 32;
    localparam int IndexWidth = 3;
    localparam int NumRegs = 8;

    localparam logic [IndexWidth-1:0] RegTimeStep = 3'd0;
    localparam logic [IndexWidth-1:0] RegPartition = 3'd1;
    localparam logic [IndexWidth-1:0] RegSurface = 3'd2;
    localparam logic [IndexWidth-1:0] RegMobility = 3'd3;
    localparam logic [IndexWidth-1:0] RegWidth = 3'd4;
    localparam logic [IndexWidth-1:0] RegRelax = 3'd5;
    localparam logic [IndexWidth-1:0] RegMu = 3'd6;
    localparam logic [IndexWidth-1:0] RegInvDx = 3'd7;

    localparam logic signed [31:0] QOne = 32'sd65536;
    localparam logic signed [31:0] QThree = 32'sd196608;

    // register file seen by the datapath
    typedef struct packed {
        logic signed [31:0] dt;
        logic signed [31:0] k;
        logic signed [31:0] g;
        logic signed [31:0] m;
        logic signed [31:0] eps;
        logic signed [31:0] tau;
        logic signed [31:0] mu;
        logic signed [31:0] idx2;
    } cfg_regs_t;

    // command from controller to datapath
    typedef struct packed {
        logic start;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic done;
    } dp_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        if (x > 66'sh0_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (x < -66'sh0_8000_0000)
            return 32'sh8000_0000;
        else
            return x[31:0];
    endfunction

    function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        return sat32(66'(a) + 66'(b));
    endfunction

    function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        return sat32(66'(a) - 66'(b));
    endfunction
endpackage
`default_nettype wire

// File: rtl/pfas_if.sv
// valid/ready channel interfaces for the stencil step unit
`default_nettype none
interface pfas_in_if;
    logic valid;
    logic ready;
    logic signed [31:0] phase_in;
    logic signed [31:0] potential_in;
    logic last_point;
    modport source (output valid, phase_in, potential_in, last_point, input ready);
    modport sink (input valid, phase_in, potential_in, last_point, output ready);
endinterface

interface pfas_out_if;
    logic valid;
    logic ready;
    logic signed [31:0] phase_out;
    logic signed [31:0] potential_out;
    logic signed [31:0] concentration_out;
    logic last_result;
    modport source (output valid, phase_out, potential_out, concentration_out,
                    last_result, input ready);
    modport sink (input valid, phase_out, potential_out, concentration_out,
                  last_result, output ready);
endinterface

interface pfas_cfg_if;
    logic valid;
    logic ready;
    logic [2:0] index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/pfas_datapath.sv
// datapath: one shared multiplier and a serial divider run a microprogram
// depends on pfas_pkg
`default_nettype none
module pfas_datapath
    import pfas_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_regs_t cfg,
    input  wire logic signed [31:0] pw0,
    input  wire logic signed [31:0] pw1,
    input  wire logic signed [31:0] pw2,
    input  wire logic signed [31:0] uw0,
    input  wire logic signed [31:0] uw1,
    input  wire logic signed [31:0] uw2,
    input  wire dp_cmd_t cmd,
    output dp_stat_t stat,
    output logic signed [31:0] pn,
    output logic signed [31:0] un,
    output logic signed [31:0] cn
);
    // scratch registers
    typedef enum logic [4:0] {
        R_P, R_U, R_LP, R_LU, R_OMP, R_KM1, R_A, R_B, R_C, R_T1, R_T2,
        R_SIX, R_DP, R_DU, R_H, R_DEN, R_PN, R_UN, R_HN, R_CN, R_X
    } rsel_t;

    typedef enum logic [1:0] {OP_MUL, OP_DIV, OP_ALU} op_t;

    // alu ops
    typedef enum logic [3:0] {
        A_SUB, A_ADD, A_LAP, A_SCALE9, A_SCALE6, A_THREE2P, A_OMX, A_KM1,
        A_INIT
    } alu_t;

    typedef struct packed {
        op_t op;
        alu_t alu;
        rsel_t a;
        rsel_t b;
        rsel_t d;
        logic bcfg;
        logic [2:0] cidx;
    } uop_t;

    localparam int NumOps = 40;
    localparam int PcWidth = $clog2(NumOps + 1);

    logic signed [31:0] rf_reg [21];
    logic signed [31:0] rf_next [21];

    function automatic uop_t mk(op_t op, alu_t alu, rsel_t a, rsel_t b, rsel_t d,
                                logic bcfg, logic [2:0] ci);
        uop_t u;
        u.op = op; u.alu = alu; u.a = a; u.b = b; u.d = d; u.bcfg = bcfg; u.cidx = ci;
        return u;
    endfunction

    // microprogram; b comes from a config register when bcfg is set
    function automatic uop_t prog(input logic [PcWidth-1:0] pc);
        uop_t u;
        u = mk(OP_ALU, A_INIT, R_P, R_P, R_X, 1'b0, RegTimeStep);
        case (pc)
            0:  u = mk(OP_ALU, A_INIT, R_P, R_P, R_X, 1'b0, RegTimeStep);
            1:  u = mk(OP_ALU, A_LAP, R_P, R_P, R_A, 1'b0, RegTimeStep);
            2:  u = mk(OP_MUL, A_ADD, R_A, R_P, R_LP, 1'b1, RegInvDx);
            3:  u = mk(OP_ALU, A_LAP, R_U, R_U, R_A, 1'b0, RegTimeStep);
            4:  u = mk(OP_MUL, A_ADD, R_A, R_P, R_LU, 1'b1, RegInvDx);
            5:  u = mk(OP_ALU, A_OMX, R_P, R_P, R_OMP, 1'b0, RegTimeStep);
            6:  u = mk(OP_MUL, A_ADD, R_P, R_P, R_A, 1'b0, RegTimeStep);
            7:  u = mk(OP_MUL, A_ADD, R_OMP, R_OMP, R_B, 1'b0, RegTimeStep);
            8:  u = mk(OP_MUL, A_ADD, R_A, R_B, R_C, 1'b0, RegTimeStep);   // well
            9:  u = mk(OP_ALU, A_KM1, R_P, R_P, R_KM1, 1'b0, RegPartition);
            10: u = mk(OP_MUL, A_ADD, R_P, R_OMP, R_A, 1'b0, RegTimeStep);
            11: u = mk(OP_ALU, A_SCALE6, R_A, R_A, R_SIX, 1'b0, RegTimeStep);
            12: u = mk(OP_ALU, A_INIT, R_X, R_X, R_A, 1'b1, RegSurface); // a = g
            13: u = mk(OP_MUL, A_ADD, R_A, R_P, R_B, 1'b1, RegWidth);
            14: u = mk(OP_MUL, A_ADD, R_B, R_LP, R_T1, 1'b0, RegTimeStep);
            15: u = mk(OP_DIV, A_ADD, R_A, R_P, R_B, 1'b1, RegWidth);
            16: u = mk(OP_ALU, A_SCALE9, R_B, R_B, R_B, 1'b0, RegTimeStep);
            17: u = mk(OP_MUL, A_ADD, R_B, R_C, R_T2, 1'b0, RegTimeStep);
            18: u = mk(OP_ALU, A_SUB, R_U, R_P, R_A, 1'b1, RegMu);
            19: u = mk(OP_MUL, A_ADD, R_A, R_KM1, R_A, 1'b0, RegTimeStep);
            20: u = mk(OP_MUL, A_ADD, R_A, R_U, R_A, 1'b0, RegTimeStep);
            21: u = mk(OP_MUL, A_ADD, R_A, R_SIX, R_A, 1'b0, RegTimeStep);
            22: u = mk(OP_ALU, A_SUB, R_T1, R_T2, R_B, 1'b0, RegTimeStep);
            23: u = mk(OP_ALU, A_ADD, R_B, R_A, R_DP, 1'b0, RegTimeStep);
            24: u = mk(OP_MUL, A_ADD, R_DP, R_P, R_A, 1'b1, RegTimeStep);
            25: u = mk(OP_DIV, A_ADD, R_A, R_P, R_A, 1'b1, RegRelax);
            26: u = mk(OP_DIV, A_ADD, R_A, R_P, R_A, 1'b1, RegWidth);
            27: u = mk(OP_ALU, A_ADD, R_P, R_A, R_PN, 1'b0, RegTimeStep);
            28: u = mk(OP_MUL, A_ADD, R_LU, R_P, R_T1, 1'b1, RegMobility);
            29: u = mk(OP_MUL, A_ADD, R_KM1, R_U, R_A, 1'b0, RegTimeStep);
            30: u = mk(OP_MUL, A_ADD, R_A, R_SIX, R_A, 1'b0, RegTimeStep);
            31: u = mk(OP_MUL, A_ADD, R_A, R_DP, R_A, 1'b0, RegTimeStep);
            32: u = mk(OP_ALU, A_SUB, R_T1, R_A, R_DU, 1'b0, RegTimeStep);
            33: u = mk(OP_ALU, A_THREE2P, R_P, R_P, R_H, 1'b0, RegTimeStep); // h(p)
            34: u = mk(OP_ALU, A_OMX, R_P, R_P, R_A, 1'b1, RegPartition);  // 1-k
            35: u = mk(OP_MUL, A_ADD, R_A, R_H, R_A, 1'b0, RegTimeStep);
            36: u = mk(OP_ALU, A_ADD, R_A, R_P, R_DEN, 1'b1, RegPartition);
            37: u = mk(OP_MUL, A_ADD, R_DU, R_P, R_A, 1'b1, RegTimeStep);
            38: u = mk(OP_DIV, A_ADD, R_A, R_DEN, R_A, 1'b0, RegTimeStep);
            39: u = mk(OP_ALU, A_ADD, R_U, R_A, R_UN, 1'b0, RegTimeStep);
            default: u = mk(OP_ALU, A_INIT, R_P, R_P, R_X, 1'b0, RegTimeStep);
        endcase
        return u;
    endfunction

    // three-step h() and concentration run as a small tail sequence
    typedef enum logic [3:0] {
        T_PP, T_3M, T_H, T_UH, T_OMH, T_K, T_KU, T_CN, T_END
    } tail_t;

    logic running_reg, running_next;
    logic tail_reg, tail_next;
    logic [PcWidth-1:0] pc_reg, pc_next;
    logic [3:0] hstep_reg, hstep_next;   // sub-steps of A_THREE2P at pc 33
    tail_t tstep_reg, tstep_next;
    logic done_reg, done_next;

    // multiplier stage
    logic mul_busy_reg, mul_busy_next;
    logic signed [63:0] prod_reg;

    // serial divider
    logic div_busy_reg, div_busy_next;
    logic div_fin_reg, div_fin_next;
    logic [5:0] div_cnt_reg, div_cnt_next;
    logic [63:0] div_num_reg, div_num_next;
    logic [31:0] div_den_reg, div_den_next;
    logic [32:0] div_rem_reg, div_rem_next;
    logic div_neg_reg, div_neg_next;

    uop_t u;
    logic signed [31:0] opa, opb;
    logic signed [31:0] cfgv;
    logic signed [31:0] mul_a, mul_b;
    logic mul_go;
    logic signed [31:0] mul_res;
    logic signed [63:0] rnd;
    logic signed [31:0] div_a, div_b;
    logic div_go;
    logic signed [31:0] div_res;
    logic [32:0] trial;
    logic [63:0] qmag;
    logic signed [31:0] wb_val;
    rsel_t wb_dst;
    logic wb_en;

    always_comb
    begin
        u = prog(pc_reg);
    end

    // config operand select
    always_comb
    begin
        unique case (u.cidx)
            RegTimeStep:  cfgv = cfg.dt;
            RegPartition: cfgv = cfg.k;
            RegSurface:   cfgv = cfg.g;
            RegMobility:  cfgv = cfg.m;
            RegWidth:     cfgv = cfg.eps;
            RegRelax:     cfgv = cfg.tau;
            RegMu:        cfgv = cfg.mu;
            RegInvDx:     cfgv = cfg.idx2;
            default:      cfgv = cfg.dt;
        endcase
        opa = rf_reg[u.a];
        opb = u.bcfg ? cfgv : rf_reg[u.b];
    end

    // multiplier result with round half up and saturation
    always_comb
    begin
        rnd = prod_reg + 64'sd32768;
        mul_res = sat32(66'(rnd >>> 16));
    end

    // divider result
    always_comb
    begin
        qmag = div_num_reg;
        if (div_neg_reg)
            div_res = sat32(-$signed({2'b00, qmag}));
        else
            div_res = sat32($signed({2'b00, qmag}));
        trial = {div_rem_reg[31:0], div_num_reg[63]} - {1'b0, div_den_reg};
    end

    // sequencer
    always_comb
    begin
        logic signed [31:0] t;
        running_next = running_reg;
        tail_next = tail_reg;
        pc_next = pc_reg;
        hstep_next = hstep_reg;
        tstep_next = tstep_reg;
        done_next = 1'b0;
        mul_go = 1'b0;
        mul_a = opa;
        mul_b = opb;
        div_go = 1'b0;
        div_a = opa;
        div_b = opb;
        wb_en = 1'b0;
        wb_dst = u.d;
        wb_val = 32'sd0;
        mul_busy_next = 1'b0;
        t = 32'sd0;
        for (int i = 0; i < 21; i++)
            rf_next[i] = rf_reg[i];

        if (running_reg && !tail_reg) begin
            if (pc_reg == 6'(33)) begin
                // h(p): pp = p*p, c = 3-2p, h = pp*c
                unique case (hstep_reg)
                    4'd0: begin
                        mul_go = 1'b1; mul_a = rf_reg[R_P]; mul_b = rf_reg[R_P];
                        hstep_next = 4'd1;
                    end
                    4'd1: begin
                        rf_next[R_B] = mul_res;
                        mul_go = 1'b1; mul_a = mul_res;
                        mul_b = qsub(QThree, sat32(66'(rf_reg[R_P]) * 66'sd2));
                        hstep_next = 4'd2;
                    end
                    default: begin
                        rf_next[R_H] = mul_res;
                        hstep_next = 4'd0;
                        pc_next = pc_reg + 1'b1;
                    end
                endcase
            end else begin
                unique case (u.op)
                    OP_MUL: begin
                        if (!mul_busy_reg) begin
                            mul_go = 1'b1;
                        end else begin
                            wb_en = 1'b1; wb_val = mul_res;
                            pc_next = pc_reg + 1'b1;
                        end
                    end
                    OP_DIV: begin
                        if (div_fin_reg) begin
                            wb_en = 1'b1; wb_val = div_res;
                            pc_next = pc_reg + 1'b1;
                        end else if (!div_busy_reg) begin
                            div_go = 1'b1;
                        end
                    end
                    default: begin
                        wb_en = 1'b1;
                        unique case (u.alu)
                            A_INIT:    wb_val = opb;
                            A_ADD:     wb_val = qadd(opa, opb);
                            A_SUB:     wb_val = qsub(opa, opb);
                            A_SCALE9:  wb_val = sat32(66'(opa) * 66'sd9);
                            A_SCALE6:  wb_val = sat32(66'(opa) * 66'sd6);
                            A_OMX:     wb_val = qsub(QOne, opb);
                            A_KM1:     wb_val = qsub(cfg.k, QOne);
                            A_LAP: begin
                                if (u.a == R_P)
                                    wb_val = sat32(66'(pw0) + 66'(pw2) - 66'sd2 * 66'(pw1));
                                else
                                    wb_val = sat32(66'(uw0) + 66'(uw2) - 66'sd2 * 66'(uw1));
                            end
                            default:   wb_val = opb;
                        endcase
                        if (pc_reg == 6'(0)) begin
                            rf_next[R_P] = pw1;
                            rf_next[R_U] = uw1;
                            wb_en = 1'b0;
                        end
                        if (pc_reg == 6'(NumOps - 1)) begin
                            tail_next = 1'b1;
                            tstep_next = T_PP;
                        end else begin
                            pc_next = pc_reg + 1'b1;
                        end
                    end
                endcase
            end
        end else if (running_reg && tail_reg) begin
            // h(pn) then concentration
            unique case (tstep_reg)
                T_PP: begin
                    mul_go = 1'b1; mul_a = rf_reg[R_PN]; mul_b = rf_reg[R_PN];
                    tstep_next = T_3M;
                end
                T_3M: begin
                    mul_go = 1'b1; mul_a = mul_res;
                    mul_b = qsub(QThree, sat32(66'(rf_reg[R_PN]) * 66'sd2));
                    tstep_next = T_H;
                end
                T_H: begin
                    rf_next[R_HN] = mul_res;
                    mul_go = 1'b1; mul_a = rf_reg[R_UN]; mul_b = mul_res;
                    tstep_next = T_UH;
                end
                T_UH: begin
                    rf_next[R_T1] = mul_res;
                    mul_go = 1'b1; mul_a = qsub(QOne, rf_reg[R_HN]); mul_b = cfg.k;
                    tstep_next = T_OMH;
                end
                T_OMH: begin
                    mul_go = 1'b1; mul_a = mul_res; mul_b = rf_reg[R_UN];
                    tstep_next = T_K;
                end
                T_K: begin
                    t = qadd(rf_reg[R_T1], mul_res);
                    rf_next[R_CN] = t;
                    tstep_next = T_END;
                end
                default: begin
                    running_next = 1'b0;
                    tail_next = 1'b0;
                    done_next = 1'b1;
                    tstep_next = T_PP;
                end
            endcase
        end else if (cmd.start) begin
            running_next = 1'b1;
            pc_next = '0;
            hstep_next = 4'd0;
        end

        if (mul_go)
            mul_busy_next = 1'b1;
        if (wb_en)
            rf_next[wb_dst] = wb_val;
    end

    // serial divider control: restoring, one quotient bit a cycle
    always_comb
    begin
        logic signed [31:0] bden;
        logic [31:0] amag;
        div_busy_next = div_busy_reg;
        div_fin_next = 1'b0;
        div_cnt_next = div_cnt_reg;
        div_num_next = div_num_reg;
        div_den_next = div_den_reg;
        div_rem_next = div_rem_reg;
        div_neg_next = div_neg_reg;
        bden = (div_b < 32'sd1) ? 32'sd1 : div_b;
        amag = div_a[31] ? 32'(-div_a) : div_a;
        if (div_go) begin
            div_busy_next = 1'b1;
            div_cnt_next = '0;
            div_num_next = {amag, 16'd0, 16'd0} >> 16;
            div_den_next = bden;
            div_rem_next = '0;
            div_neg_next = div_a[31];
        end else if (div_busy_reg) begin
            if (!trial[32]) begin
                div_rem_next = trial;
                div_num_next = {div_num_reg[62:0], 1'b1};
            end else begin
                div_rem_next = {div_rem_reg[31:0], div_num_reg[63]};
                div_num_next = {div_num_reg[62:0], 1'b0};
            end
            div_cnt_next = div_cnt_reg + 1'b1;
            if (div_cnt_reg == 6'd63) begin
                div_busy_next = 1'b0;
                div_fin_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            running_reg <= 1'b0;
            tail_reg <= 1'b0;
            pc_reg <= '0;
            hstep_reg <= '0;
            tstep_reg <= T_PP;
            done_reg <= 1'b0;
            mul_busy_reg <= 1'b0;
            div_busy_reg <= 1'b0;
            div_fin_reg <= 1'b0;
            div_cnt_reg <= '0;
        end else begin
            running_reg <= running_next;
            tail_reg <= tail_next;
            pc_reg <= pc_next;
            hstep_reg <= hstep_next;
            tstep_reg <= tstep_next;
            done_reg <= done_next;
            mul_busy_reg <= mul_busy_next;
            div_busy_reg <= div_busy_next;
            div_fin_reg <= div_fin_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        div_num_reg <= div_num_next;
        div_den_reg <= div_den_next;
        div_rem_reg <= div_rem_next;
        div_neg_reg <= div_neg_next;
        for (int i = 0; i < 21; i++)
            rf_reg[i] <= rf_next[i];
    end

    assign stat.done = done_reg;
    assign pn = rf_reg[R_PN];
    assign un = rf_reg[R_UN];
    assign cn = rf_reg[R_CN];
endmodule
`default_nettype wire

// File: rtl/pfas_ctrl.sv
// controller: input window, point count, result sequencing
// depends on pfas_pkg and pfas_if
`default_nettype none
module pfas_ctrl
    import pfas_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    pfas_in_if.sink in_ch,
    pfas_out_if.source out_ch,
    output dp_cmd_t cmd,
    input  wire dp_stat_t stat,
    input  wire logic signed [31:0] pn,
    input  wire logic signed [31:0] un,
    input  wire logic signed [31:0] cn,
    output logic signed [31:0] pw0,
    output logic signed [31:0] pw1,
    output logic signed [31:0] pw2,
    output logic signed [31:0] uw0,
    output logic signed [31:0] uw1,
    output logic signed [31:0] uw2
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CALC = 4'b0010,
        S_EMIT1 = 4'b0100,
        S_EMIT2 = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] seen_reg, seen_next;
    logic first_reg, first_next;
    logic last_reg, last_next;
    logic signed [31:0] pw_reg [3];
    logic signed [31:0] uw_reg [3];
    logic accept;

    assign accept = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        seen_next = seen_reg;
        first_next = first_reg;
        last_next = last_reg;
        cmd.start = 1'b0;
        out_ch.valid = 1'b0;
        out_ch.last_result = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    first_next = (seen_reg == 2'd2);
                    last_next = in_ch.last_point;
                    if (seen_reg >= 2'd2) begin
                        cmd.start = 1'b1;
                        state_next = S_CALC;
                        seen_next = 2'd3;
                    end else begin
                        seen_next = seen_reg + 1'b1;
                    end
                    if (in_ch.last_point)
                        seen_next = (seen_reg >= 2'd2) ? 2'd3 : 2'd0;
                end
            end
            S_CALC: begin
                if (stat.done)
                    state_next = S_EMIT1;
            end
            S_EMIT1: begin
                out_ch.valid = 1'b1;
                if (out_ch.ready) begin
                    if (first_reg || last_reg)
                        state_next = S_EMIT2;
                    else
                        state_next = S_IDLE;
                end
            end
            S_EMIT2: begin
                out_ch.valid = 1'b1;
                out_ch.last_result = last_reg;
                if (out_ch.ready) begin
                    state_next = S_IDLE;
                    if (last_reg)
                        seen_next = 2'd0;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            seen_reg <= '0;
            first_reg <= 1'b0;
            last_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                pw_reg[i] <= '0;
                uw_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            seen_reg <= seen_next;
            first_reg <= first_next;
            last_reg <= last_next;
            if (accept) begin
                pw_reg[0] <= (in_ch.last_point && seen_reg < 2'd2) ? '0 : pw_reg[1];
                pw_reg[1] <= (in_ch.last_point && seen_reg < 2'd2) ? '0 : pw_reg[2];
                pw_reg[2] <= (in_ch.last_point && seen_reg < 2'd2) ? '0 : in_ch.phase_in;
                uw_reg[0] <= (in_ch.last_point && seen_reg < 2'd2) ? '0 : uw_reg[1];
                uw_reg[1] <= (in_ch.last_point && seen_reg < 2'd2) ? '0 : uw_reg[2];
                uw_reg[2] <= (in_ch.last_point && seen_reg < 2'd2) ? '0 : in_ch.potential_in;
            end else if (state_reg == S_EMIT2 && out_ch.ready && last_reg) begin
                for (int i = 0; i < 3; i++)
                begin
                    pw_reg[i] <= '0;
                    uw_reg[i] <= '0;
                end
            end
        end
    end

    assign pw0 = pw_reg[0];
    assign pw1 = pw_reg[1];
    assign pw2 = pw_reg[2];
    assign uw0 = uw_reg[0];
    assign uw1 = uw_reg[1];
    assign uw2 = uw_reg[2];
    assign out_ch.phase_out = pn;
    assign out_ch.potential_out = un;
    assign out_ch.concentration_out = cn;
endmodule
`default_nettype wire

// File: rtl/phase_field_alloy_stencil_step_unit.sv
// top level of the phase-field alloy stencil step unit
// depends on pfas_pkg, pfas_if, pfas_ctrl, pfas_datapath
//
//   port      dir    payload
//   in_ch     sink   phase_in, potential_in, last_point
//   out_ch    source phase_out, potential_out, concentration_out, last_result
//   cfg       sink   index, data
//
// an interior point presents its first result once its microprogram is done:
// four divisions on the one-bit-a-cycle divider, 19 products on the shared
// multiplier, 16 alu steps, the h(p) steps and the concentration tail, then
// the done flag
// points that only fill the window start no computation; results are held until taken
// no input point is accepted while a point is computed or its results are pending
// reset loads the register defaults and clears the window and point count
`default_nettype none
module phase_field_alloy_stencil_step_unit
    import pfas_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    pfas_in_if.sink in_ch,
    pfas_out_if.source out_ch,
    pfas_cfg_if.sink cfg
);
    cfg_regs_t regs_reg;
    dp_cmd_t cmd;
    dp_stat_t stat;
    logic signed [31:0] pn, un, cn;
    logic signed [31:0] pw0, pw1, pw2, uw0, uw1, uw2;

    assign cfg.ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            regs_reg.dt <= 32'sd1966;
            regs_reg.k <= 32'sd32768;
            regs_reg.g <= QOne;
            regs_reg.m <= QOne;
            regs_reg.eps <= QOne;
            regs_reg.tau <= QOne;
            regs_reg.mu <= QOne;
            regs_reg.idx2 <= QOne;
        end else if (cfg.valid) begin
            unique case (cfg.index)
                RegTimeStep:  regs_reg.dt <= {15'd0, cfg.data[16:0]};
                RegPartition: regs_reg.k <= {15'd0, cfg.data[16:0]};
                RegSurface:   regs_reg.g <= {1'b0, cfg.data[30:0]};
                RegMobility:  regs_reg.m <= {1'b0, cfg.data[30:0]};
                RegWidth:     regs_reg.eps <= {1'b0, cfg.data[30:0]};
                RegRelax:     regs_reg.tau <= {1'b0, cfg.data[30:0]};
                RegMu:        regs_reg.mu <= cfg.data;
                RegInvDx:     regs_reg.idx2 <= {1'b0, cfg.data[30:0]};
                default:      regs_reg.dt <= regs_reg.dt;
            endcase
        end
    end

    pfas_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .cmd(cmd), .stat(stat), .pn(pn), .un(un), .cn(cn),
        .pw0(pw0), .pw1(pw1), .pw2(pw2), .uw0(uw0), .uw1(uw1), .uw2(uw2)
    );

    pfas_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cfg(regs_reg),
        .pw0(pw0), .pw1(pw1), .pw2(pw2), .uw0(uw0), .uw1(uw1), .uw2(uw2),
        .cmd(cmd), .stat(stat), .pn(pn), .un(un), .cn(cn)
    );
endmodule
`default_nettype wire
